>>> sv/connection_table_cam_assert.svh
// Assertion macros for the connection table.
// Clock clk and active-low reset rst_n must be in scope at each use.
`ifndef CONNECTION_TABLE_CAM_ASSERT_SVH
`define CONNECTION_TABLE_CAM_ASSERT_SVH

// Same-cycle implication.
`define CTC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("connection table check failed");

// Next-cycle implication.
`define CTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("connection table check failed");

`endif

>>> sv/ctc_pkg.sv
package ctc_pkg;

  localparam logic [1:0] KIND_FIND    = 2'd0;
  localparam logic [1:0] KIND_TAKE    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_CLEAR   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_NOROOM   = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd3;

  typedef struct packed {
    logic [31:0] laddr;
    logic [15:0] lport;
    logic [31:0] raddr;
    logic [15:0] rport;
  } ctc_key_t;

  // Commit controls, valid in the resolve cycle only.
  typedef struct packed {
    logic       claim;
    logic       rel;
    logic       clr;
    logic [3:0] slot;
  } ctc_ctl_t;

  // Priority chain between neighboring cells.
  typedef struct packed {
    logic       hit;
    logic       free;
    logic [3:0] hit_idx;
    logic [3:0] free_idx;
  } ctc_link_t;

endpackage

>>> sv/ctc_cell.sv
module ctc_cell import ctc_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctc_key_t  key_i,
  input  ctc_ctl_t  ctl_i,
  input  ctc_link_t link_i,
  output ctc_link_t link_o
);

  localparam logic [6:0] IDX7 = 7'(IDX);
  localparam logic [3:0] IDX4 = 4'(IDX);

  logic     in_use_r, in_use_nxt;
  ctc_key_t key_r, key_nxt;
  logic     hit_r, free_r;
  logic     first_free;
  logic     claim_me, rel_me;

  assign first_free = free_r && !link_i.free;
  assign claim_me   = ctl_i.claim && first_free;
  assign rel_me     = ctl_i.clr || (ctl_i.rel && ({3'b000, ctl_i.slot} == IDX7));

  always_comb begin
    in_use_nxt = in_use_r;
    key_nxt    = key_r;
    if (rel_me) begin
      in_use_nxt = 1'b0;
      key_nxt    = '0;
    end else if (claim_me) begin
      in_use_nxt = 1'b1;
      key_nxt    = key_i;
    end
  end

  always_comb begin
    link_o.hit      = link_i.hit || hit_r;
    link_o.free     = link_i.free || free_r;
    link_o.hit_idx  = link_i.hit ? link_i.hit_idx : (hit_r ? IDX4 : 4'd0);
    link_o.free_idx = link_i.free ? link_i.free_idx : (free_r ? IDX4 : 4'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= 1'b0;
    end else begin
      in_use_r <= in_use_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    hit_r  <= in_use_r && (key_r == key_i);
    free_r <= !in_use_r;
  end

endmodule

>>> sv/connection_table_cam.sv
// Channel   Ports                                   Direction  Handshake
// input     start, busy, in_kind .. in_slot         in         beat when start && !busy
// result    out_valid, out_status .. out_refused_count out      beat when out_valid
//
// Every beat goes through latch, compare in every cell, then resolve along
// the cell chain and commit. busy is high for the compare and resolve cycles; the
// next beat can be taken on the cycle out_valid is high. Reset (rst_n low, synchronous)
// frees every slot and zeroes the refusal counter. out_valid is a one-cycle
// strobe; the receiver cannot stall it.
`include "connection_table_cam_assert.svh"

module connection_table_cam import ctc_pkg::*; #(
  parameter int SLOTS         = 16,
  parameter int ADDRESS_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_local_address,
  input  logic [15:0] in_local_port,
  input  logic [31:0] in_remote_address,
  input  logic [15:0] in_remote_port,
  input  logic [3:0]  in_slot,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot_index,
  output logic [31:0] out_refused_count
);

  localparam int          ADDR_BITS = ADDRESS_BYTES * 8;
  localparam logic [31:0] ADDR_MASK =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMP  = 2'd1;
  localparam logic [1:0] PH_RES  = 2'd2;

  logic [1:0]  ph_r, ph_nxt;
  logic [1:0]  kind_r;
  logic [3:0]  slot_r;
  ctc_key_t    key_r;
  logic [31:0] refusals_r, refusals_nxt;
  logic        valid_r;
  logic [1:0]  status_r, status_nxt;
  logic [3:0]  index_r, index_nxt;
  logic        accept;
  ctc_ctl_t    ctl;
  ctc_link_t   links [0:SLOTS];
  ctc_link_t   tail;

  assign busy   = (ph_r != PH_IDLE);
  assign accept = start && !busy;
  assign tail   = links[SLOTS];
  assign links[0] = '0;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      ctc_cell #(.IDX(g)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .key_i  (key_r),
        .ctl_i  (ctl),
        .link_i (links[g]),
        .link_o (links[g+1])
      );
    end
  endgenerate

  always_comb begin
    ctl.claim = (ph_r == PH_RES) && (kind_r == KIND_TAKE) && !tail.hit;
    ctl.rel   = (ph_r == PH_RES) && (kind_r == KIND_RELEASE);
    ctl.clr   = (ph_r == PH_RES) && (kind_r == KIND_CLEAR);
    ctl.slot  = slot_r;
  end

  always_comb begin
    status_nxt   = ST_DONE;
    index_nxt    = 4'd0;
    refusals_nxt = refusals_r;
    case (kind_r)
      KIND_FIND: begin
        if (tail.hit) begin
          status_nxt = ST_OK;
          index_nxt  = tail.hit_idx;
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      KIND_TAKE: begin
        if (tail.hit) begin
          status_nxt = ST_OK;
          index_nxt  = tail.hit_idx;
        end else if (tail.free) begin
          status_nxt = ST_OK;
          index_nxt  = tail.free_idx;
        end else begin
          status_nxt   = ST_NOROOM;
          refusals_nxt = refusals_r + 32'd1;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  always_comb begin
    case (ph_r)
      PH_IDLE: ph_nxt = accept ? PH_CMP : PH_IDLE;
      PH_CMP:  ph_nxt = PH_RES;
      PH_RES:  ph_nxt = PH_IDLE;
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r       <= PH_IDLE;
      valid_r    <= 1'b0;
      refusals_r <= 32'd0;
    end else begin
      ph_r    <= ph_nxt;
      valid_r <= (ph_r == PH_RES);
      if (ph_r == PH_RES) begin
        refusals_r <= refusals_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r      <= in_kind;
      slot_r      <= in_slot;
      key_r.laddr <= in_local_address & ADDR_MASK;
      key_r.lport <= in_local_port;
      key_r.raddr <= in_remote_address & ADDR_MASK;
      key_r.rport <= in_remote_port;
    end
    if (ph_r == PH_RES) begin
      status_r <= status_nxt;
      index_r  <= index_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_slot_index    = index_r;
  assign out_refused_count = refusals_r;

  `CTC_ASSERT_NEXT(a_accept_to_cmp, accept, ph_r == PH_CMP)
  `CTC_ASSERT_NEXT(a_res_to_result, ph_r == PH_RES, out_valid && (ph_r == PH_IDLE))
  `CTC_ASSERT_NOW(a_index_zero, out_valid && (out_status != ST_OK), out_slot_index == 4'd0)
  `CTC_ASSERT_NEXT(a_refusal_count, (ph_r == PH_RES) && (status_nxt == ST_NOROOM),
                   refusals_r == $past(refusals_r) + 32'd1)

endmodule
